FILE: sv/rmslm_pkg.sv
// rmslm_pkg: shared types and constants for the block rms level meter
// no dependencies; imported by every module of the meter

package rmslm_pkg;

    // sample format, fixed by the stream word
    localparam int SMP_W         = 16;
    localparam int GAIN_W        = 16;
    localparam int LVL_W         = 16;
    localparam int RT_W          = SMP_W;
    localparam int MUL_W         = (SMP_W > GAIN_W) ? SMP_W : GAIN_W;
    localparam int SCALE_SH      = SMP_W - 9;
    localparam int MAX_BLOCK_DEF = 4096;

    // gain reset value, 10.0 in unsigned q9.7
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd1280;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV,
        ST_ROOT,
        ST_SCALE
    } rmslm_state_t;

    // one finished result
    typedef struct packed {
        logic             forced_end;
        logic [LVL_W-1:0] level;
    } rmslm_res_t;

endpackage

FILE: sv/block_rms_level_meter_core.sv
// block_rms_level_meter_core: top level, gain register and output word register
// depends on rmslm_pkg and rmslm_engine
//
// channel  | direction | word
// s_axis   | in        | tdata = sample, tlast = last
// m_axis   | out       | tdata = level, tuser = forced_end
// cfg      | in        | data = gain, unsigned q9.7
//
// a sample that does not close a block passes through accept, square and add
// a closing sample adds a restoring divide, a 16-bit root and a scale step; the sum
// is SUM_W = 2*16-1 + clog2(MAX_BLOCK+1) - 1 bits wide, 43 at 4096
// divide and root share one compare/subtract unit, square and scale one multiplier
// reset clears the sum, count and gain (10.0); no clearing pass
// s_axis_tready is low while a word is in work; a stalled result waits in the
// output register and the next sample is still taken

module block_rms_level_meter_core
    import rmslm_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [SMP_W-1:0]  s_axis_tdata,   // [15:0] sample
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [LVL_W-1:0]  m_axis_tdata,   // [15:0] level
    output logic              m_axis_tuser,   // [0] forced_end
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [GAIN_W-1:0] cfg_data
);

    logic [GAIN_W-1:0] gain_reg;
    logic              out_valid_reg;
    rmslm_res_t        out_res_reg;
    logic              out_free;
    logic              res_load;
    rmslm_res_t        res;

    rmslm_engine #(.MAX_BLOCK(MAX_BLOCK)) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sample   (s_axis_tdata),
        .last     (s_axis_tlast),
        .gain     (gain_reg),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res)
    );

    // gain register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= GAIN_RST;
        else if (cfg_valid)
            gain_reg <= cfg_data;
    end

    // output word register
    assign out_free = ~out_valid_reg | m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg.level;
    assign m_axis_tuser  = out_res_reg.forced_end;

endmodule

FILE: sv/rmslm_alu.sv
// rmslm_alu: shared multiplier and compare/subtract unit of the meter
// depends on rmslm_pkg

module rmslm_alu
    import rmslm_pkg::*;
#(
    parameter int W = 20
)
(
    input  logic [W-1:0]         cmp_a,
    input  logic [W-1:0]         cmp_b,
    output logic [W-1:0]         diff,
    output logic                 ge,
    input  logic [MUL_W-1:0]     mul_a,
    input  logic [MUL_W-1:0]     mul_b,
    output logic [2*MUL_W-1:0]   prod
);

    logic [W:0] sub_full;

    // trial subtract, borrow out gives the compare
    assign sub_full = {1'b0, cmp_a} - {1'b0, cmp_b};
    assign diff     = sub_full[W-1:0];
    assign ge       = ~sub_full[W];

    // unsigned product
    assign prod = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

endmodule

FILE: sv/rmslm_engine.sv
// rmslm_engine: sequencer and datapath; square, accumulate, divide, root, scale
// depends on rmslm_pkg and rmslm_alu

module rmslm_engine
    import rmslm_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SMP_W-1:0]  sample,
    input  logic              last,
    input  logic [GAIN_W-1:0] gain,
    input  logic              out_free,
    output logic              res_load,
    output rmslm_res_t        res
);

    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int SQ_W   = 2 * SMP_W - 1;
    localparam int SUM_W  = SQ_W + CNT_W - 1;
    localparam int ALU_W  = (CNT_W + 1 > RT_W + 4) ? CNT_W + 1 : RT_W + 4;
    localparam int STEP_N = (SUM_W > RT_W) ? SUM_W : RT_W;
    localparam int STEP_W = $clog2(STEP_N);
    localparam int RAD_W  = 2 * RT_W;

    rmslm_state_t state_reg, state_next;

    logic [SMP_W-1:0]  mag_reg, mag_next;
    logic              last_reg, last_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ALU_W-1:0]  rem_reg, rem_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [RT_W-1:0]   root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              forced_reg, forced_next;

    logic [ALU_W-1:0]       cmp_a, cmp_b, diff;
    logic                   ge;
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [2*MUL_W-1:0]     prod, scaled;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   full;
    logic [SUM_W-1:0]       quo_shift;
    logic [SUM_W+RAD_W-1:0] quo_wide;
    logic [SMP_W-1:0]       sample_mag;

    // shared arithmetic
    rmslm_alu #(.W(ALU_W)) u_alu (
        .cmp_a (cmp_a),
        .cmp_b (cmp_b),
        .diff  (diff),
        .ge    (ge),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // magnitude; most negative sample maps to 2^(SMP_W-1)
    assign sample_mag = sample[SMP_W-1] ? SMP_W'(~sample + SMP_W'(1)) : sample;

    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign full      = (cnt_inc == CNT_W'(MAX_BLOCK));
    assign quo_shift = {sum_reg[SUM_W-2:0], ge};
    assign quo_wide  = {{RAD_W{1'b0}}, quo_shift};

    // scale by gain and saturate
    assign scaled = prod >> SCALE_SH;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SQUARE;
            end
            ST_SQUARE: state_next = ST_ACCUM;
            ST_ACCUM:
            begin
                if (last_reg || full)
                    state_next = ST_DIV;
                else
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (step_reg == '0)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and shared unit operand select
    always_comb
    begin
        in_ready = 1'b0;
        res_load = 1'b0;
        mul_a    = MUL_W'(root_reg);
        mul_b    = MUL_W'(gain);
        cmp_a    = {rem_reg[ALU_W-3:0], rad_reg[RAD_W-1 -: 2]};
        cmp_b    = ALU_W'({root_reg, 2'b01});
        unique case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_SQUARE:
            begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(mag_reg);
            end
            ST_DIV:
            begin
                cmp_a = {rem_reg[ALU_W-2:0], sum_reg[SUM_W-1]};
                cmp_b = ALU_W'(cnt_reg);
            end
            ST_SCALE:  res_load = out_free;
            default:   ;
        endcase
    end

    assign res.forced_end = forced_reg;
    assign res.level      = (|scaled[2*MUL_W-1:LVL_W]) ? {LVL_W{1'b1}} : scaled[LVL_W-1:0];

    // datapath next values
    always_comb
    begin
        mag_next    = mag_reg;
        last_next   = last_reg;
        sq_next     = sq_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        rad_next    = rad_reg;
        root_next   = root_reg;
        step_next   = step_reg;
        forced_next = forced_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                mag_next  = sample_mag;
                last_next = last;
            end
            ST_SQUARE: sq_next = prod[SQ_W-1:0];
            ST_ACCUM:
            begin
                sum_next = sum_reg + SUM_W'(sq_reg);
                cnt_next = cnt_inc;
                if (last_reg || full)
                begin
                    rem_next    = '0;
                    step_next   = STEP_W'(SUM_W - 1);
                    forced_next = full & ~last_reg;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle, shifted into the sum register
                rem_next  = ge ? diff : cmp_a;
                sum_next  = quo_shift;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    rad_next  = quo_wide[RAD_W-1:0];
                    sum_next  = '0;
                    cnt_next  = '0;
                    rem_next  = '0;
                    root_next = '0;
                    step_next = STEP_W'(RT_W - 1);
                end
            end
            ST_ROOT:
            begin
                // one root bit per cycle, two radicand bits consumed
                rem_next  = ge ? diff : cmp_a;
                root_next = {root_reg[RT_W-2:0], ge};
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg - STEP_W'(1);
            end
            default: ;
        endcase
    end

    // control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        last_reg   <= last_next;
        sq_reg     <= sq_next;
        rem_reg    <= rem_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        step_reg   <= step_next;
        forced_reg <= forced_next;
    end

endmodule

FILE: sv/rmslm_checker.sv
// rmslm_checker: port-level assertions for block_rms_level_meter_core
// depends on rmslm_pkg; bound to the top level below

module rmslm_checker
    import rmslm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [LVL_W-1:0]  m_axis_tdata,
    input logic              m_axis_tuser,
    input logic              cfg_ready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // an accepted sample keeps the input side busy for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after an accept");

    // a new result is loaded only from the busy scale step
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while input side was idle");

    // a block never closes without the input side having been busy before it
    a_result_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ##0 $past(!s_axis_tready, 2))
        else $error("result appeared too soon after idle");

    // gain register always takes writes
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind block_rms_level_meter_core rmslm_checker u_rmslm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_ready     (cfg_ready)
);
